// ===== src/b2da_pkg.sv =====
// b2da_pkg: types, constants and the double-dabble step shared by the
// binary to decimal ascii converter. No dependencies.
package b2da_pkg;

  localparam int MAX_DIGITS      = 10;
  localparam int VALUE_W         = 33;
  localparam int MAG_W           = 33;
  localparam int MIN_W           = 4;
  localparam int CHAR_W          = 6;
  localparam int LEN_W           = 4;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int STEPS_PER_STAGE = 4;
  localparam int N_STAGES        = (MAG_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int BIN_W           = N_STAGES * STEPS_PER_STAGE;
  localparam int POS_W           = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W           = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'h2D;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [MIN_W-1:0]          min_digits;
  } b2da_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
    logic [LEN_W-1:0]  text_length;
  } b2da_out_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
    logic             neg;
    logic [CNT_W-1:0] min_digits;
  } b2da_stage_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGITS
  } b2da_emit_e;

  // one shift-add-3 step; the bit shifted out at the top of the bcd word is dropped
  function automatic b2da_stage_t dabble_step(b2da_stage_t s);
    b2da_stage_t r;
    r = s;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (r.bcd[4*d +: 4] >= 4'd5) begin
        r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
      end
    end
    r.bcd = {r.bcd[BCD_W-2:0], r.bin[BIN_W-1]};
    r.bin = {r.bin[BIN_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

// ===== src/b2da_sign.sv =====
// b2da_sign: first pipeline stage, splits sign and magnitude and clamps
// the minimum digit count. Depends on b2da_pkg.
module b2da_sign (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  b2da_pkg::b2da_in_t    data_i,
  output logic                  ready_o,
  input  logic                  ready_i,
  output logic                  valid_o,
  output b2da_pkg::b2da_stage_t data_o
);
  import b2da_pkg::*;

  logic             valid_q;
  b2da_stage_t      data_q;
  b2da_stage_t      data_d;
  logic [MAG_W-1:0] raw;
  logic [MAG_W-1:0] mag;
  logic             neg;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    raw            = MAG_W'($unsigned(data_i.value));
    neg            = data_i.value[VALUE_W-1];
    // -2^32 negates to 2^32, which still fits the unsigned magnitude
    mag            = neg ? (~raw + 1'b1) : raw;
    data_d.bcd     = '0;
    data_d.bin     = BIN_W'(mag);
    data_d.neg     = neg;
    if (int'(data_i.min_digits) > MAX_DIGITS) begin
      data_d.min_digits = CNT_W'(MAX_DIGITS);
    end else begin
      data_d.min_digits = CNT_W'(data_i.min_digits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== src/b2da_dabble.sv =====
// b2da_dabble: one double-dabble pipeline stage, STEPS_PER_STAGE shift-add-3 steps
// per register. Depends on b2da_pkg.
module b2da_dabble (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  b2da_pkg::b2da_stage_t data_i,
  output logic                  ready_o,
  input  logic                  ready_i,
  output logic                  valid_o,
  output b2da_pkg::b2da_stage_t data_o
);
  import b2da_pkg::*;

  logic        valid_q;
  b2da_stage_t data_q;
  b2da_stage_t data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== src/b2da_emit.sv =====
// b2da_emit: serializer that writes the sign and the digits one character
// per cycle from the finished bcd word. Depends on b2da_pkg.
module b2da_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  b2da_pkg::b2da_stage_t data_i,
  output logic                  ready_o,
  output logic                  strobe_o,
  output b2da_pkg::b2da_out_t   result_o
);
  import b2da_pkg::*;

  b2da_emit_e       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [BCD_W-1:0] bcd_q;
  logic [LEN_W-1:0] len_q;
  logic             strobe_q, strobe_d;
  b2da_out_t        res_q, res_d;

  logic             load;
  logic [CNT_W-1:0] nz;
  logic [CNT_W-1:0] ndig;
  logic [POS_W-1:0] ld_pos;
  logic [LEN_W-1:0] ld_len;
  logic [3:0]       digit;

  assign ready_o  = (state_q == EM_IDLE) || (state_q == EM_DIGITS && pos_q == '0);
  assign load     = valid_i && ready_o;
  assign strobe_o = strobe_q;
  assign result_o = res_q;

  // count of significant digits, at least one, padded up to the minimum
  always_comb begin
    nz = CNT_W'(1);
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (data_i.bcd[4*d +: 4] != 4'd0) begin
        nz = CNT_W'(d + 1);
      end
    end
    ndig   = (data_i.min_digits > nz) ? data_i.min_digits : nz;
    ld_pos = POS_W'(ndig - 1'b1);
    ld_len = LEN_W'(int'(ndig) + int'(data_i.neg));
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      EM_IDLE: begin
        state_d = EM_IDLE;
      end
      EM_SIGN: begin
        state_d = EM_DIGITS;
      end
      EM_DIGITS: begin
        if (pos_q == '0) begin
          state_d = EM_IDLE;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
    if (load) begin
      state_d = data_i.neg ? EM_SIGN : EM_DIGITS;
      pos_d   = ld_pos;
    end
  end

  always_comb begin
    digit    = bcd_q[pos_q*4 +: 4];
    strobe_d = 1'b0;
    res_d    = '0;
    unique case (state_q)
      EM_IDLE: begin
        strobe_d = 1'b0;
      end
      EM_SIGN: begin
        strobe_d        = 1'b1;
        res_d.text_char = ASCII_MINUS;
      end
      EM_DIGITS: begin
        strobe_d          = 1'b1;
        res_d.text_char   = ASCII_ZERO + CHAR_W'(digit);
        res_d.last_char   = (pos_q == '0);
        res_d.text_length = (pos_q == '0) ? len_q : '0;
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EM_IDLE;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load) begin
      bcd_q <= data_i.bcd;
      len_q <= ld_len;
    end
  end

endmodule

// ===== src/binary_to_decimal_ascii_core.sv =====
// binary_to_decimal_ascii_core: top level, sign stage, double-dabble
// pipeline and character serializer. Depends on b2da_pkg and the b2da_* modules.
// The first character passes through the sign stage, nine dabble stages and the
// serializer, then one character a cycle follows.
// The serializer holds an item until it has written all of its text, 1 to 11 characters;
// the pipeline takes one item per cycle while it has room, busy_o marks when full.
// Reset clears all valid bits and the serializer state; the receiver cannot stall.
module binary_to_decimal_ascii_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  b2da_pkg::b2da_in_t  in_i,
  output logic                strobe_o,
  output b2da_pkg::b2da_out_t result_o
);
  import b2da_pkg::*;

  logic        sign_ready;
  logic        st_valid [N_STAGES+1];
  logic        st_ready [N_STAGES+1];
  b2da_stage_t st_data  [N_STAGES+1];

  assign busy_o = !sign_ready;

  b2da_sign u_sign (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .data_i  (in_i),
    .ready_o (sign_ready),
    .ready_i (st_ready[0]),
    .valid_o (st_valid[0]),
    .data_o  (st_data[0])
  );

  for (genvar g = 0; g < N_STAGES; g++) begin : g_dabble
    b2da_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .data_i  (st_data[g]),
      .ready_o (st_ready[g]),
      .ready_i (st_ready[g+1]),
      .valid_o (st_valid[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  b2da_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (st_valid[N_STAGES]),
    .data_i   (st_data[N_STAGES]),
    .ready_o  (st_ready[N_STAGES]),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.text_char == ASCII_MINUS) ||
                 ((result_o.text_char >= ASCII_ZERO) &&
                  (result_o.text_char <= ASCII_ZERO + 6'd9)))
    else $error("character outside sign and digits");

  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.text_char == ASCII_MINUS) |=>
      (strobe_o && result_o.text_char != ASCII_MINUS))
    else $error("sign not followed by a digit");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.last_char ? (result_o.text_length != '0)
                                     : (result_o.text_length == '0)))
    else $error("text length inconsistent with last flag");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.last_char) |-> (result_o.text_char != ASCII_MINUS))
    else $error("text ended on the sign");

endmodule
